// ----- rtl/core/pqls_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package pqls_pkg;

  localparam int DEPTH = 16;
  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  localparam int VAL_W = 32;
  localparam int PRI_W = 16;

  // action codes
  localparam logic [1:0] ACT_ENQ  = 2'd0;
  localparam logic [1:0] ACT_PEEK = 2'd1;
  localparam logic [1:0] ACT_DEQ  = 2'd2;

  // status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  typedef struct packed {
    logic signed [VAL_W-1:0] value;
    logic signed [PRI_W-1:0] prio;
  } entry_t;

  // controller -> datapath
  typedef struct packed {
    logic item_load;
    logic enq_wr;
    logic scan_en;
    logic shift_start;
    logic shift_en;
    logic fill_dec;
    logic out_load;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic full;
    logic empty;
    logic walk_done;
    logic is_deq;
    logic out_vld;
  } sts_t;

endpackage

`default_nettype wire

// ----- rtl/core/pqls_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none

module pqls_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  input  wire logic [1:0]    in_action,
  output logic               in_ready,
  input  wire logic          out_ready,
  input  wire pqls_pkg::sts_t sts,
  output pqls_pkg::cmd_t     cmd
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_ENQ   = 5'b00010,
    S_SCAN  = 5'b00100,
    S_SHIFT = 5'b01000,
    S_DONE  = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  logic acc;

  assign in_ready = (state_r == S_IDLE);
  assign acc      = in_valid && in_ready;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (acc) begin
          cmd.item_load = 1'b1;
          if (in_action == pqls_pkg::ACT_ENQ) begin
            state_nxt = sts.full ? S_DONE : S_ENQ;
          end else if (in_action == pqls_pkg::ACT_PEEK ||
                       in_action == pqls_pkg::ACT_DEQ) begin
            state_nxt = sts.empty ? S_DONE : S_SCAN;
          end else begin
            state_nxt = S_DONE;
          end
        end
      end
      S_ENQ: begin
        cmd.enq_wr = 1'b1;
        state_nxt  = S_DONE;
      end
      S_SCAN: begin
        cmd.scan_en = 1'b1;
        if (sts.walk_done) begin
          if (sts.is_deq) begin
            cmd.shift_start = 1'b1;
            state_nxt       = S_SHIFT;
          end else begin
            state_nxt = S_DONE;
          end
        end
      end
      S_SHIFT: begin
        cmd.shift_en = 1'b1;
        if (sts.walk_done) begin
          cmd.fill_dec = 1'b1;
          state_nxt    = S_DONE;
        end
      end
      S_DONE: begin
        if (!sts.out_vld || out_ready) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/pqls_dpath.sv -----
`timescale 1ns / 1ps
`default_nettype none

module pqls_dpath (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic [1:0]                        in_action,
  input  wire logic signed [pqls_pkg::VAL_W-1:0] in_item_value,
  input  wire logic signed [pqls_pkg::PRI_W-1:0] in_item_priority,
  input  wire logic                              out_ready,
  input  wire pqls_pkg::cmd_t                    cmd,
  output pqls_pkg::sts_t                         sts,
  output logic                                   out_valid,
  output logic signed [pqls_pkg::VAL_W-1:0]      out_value,
  output logic signed [pqls_pkg::PRI_W-1:0]      out_priority,
  output logic [1:0]                             out_status,
  output logic [pqls_pkg::CNT_W-1:0]             out_entry_count
);

  localparam int IW = pqls_pkg::IDX_W;
  localparam int CW = pqls_pkg::CNT_W;

  pqls_pkg::entry_t mem [pqls_pkg::DEPTH];

  // held item
  logic [1:0]       act_r;
  pqls_pkg::entry_t item_r;
  logic [1:0]       st_r;

  // walk pointer and registered read
  logic [CW-1:0]    fill_r, fill_nxt;
  logic [CW-1:0]    ptr_r;
  logic             rd_vld_r;
  logic [IW-1:0]    rd_idx_r;
  pqls_pkg::entry_t rd_data_r;

  // best entry so far
  logic [IW-1:0]    best_idx_r;
  pqls_pkg::entry_t best_r;

  logic             out_vld_r;
  logic signed [pqls_pkg::VAL_W-1:0] out_value_r;
  logic signed [pqls_pkg::PRI_W-1:0] out_prio_r;
  logic [1:0]       out_st_r;
  logic [CW-1:0]    out_cnt_r;

  logic             walking;
  logic             rd_go;
  logic             take;
  logic             full;
  logic             empty;
  logic [1:0]       st_in;
  logic             wr_en;
  logic [IW-1:0]    wr_addr;
  pqls_pkg::entry_t wr_data;
  logic             returns_entry;

  assign full    = (fill_r == CW'(pqls_pkg::DEPTH));
  assign empty   = (fill_r == '0);
  assign walking = cmd.scan_en || cmd.shift_en;
  assign rd_go   = walking && (ptr_r < fill_r);
  assign take    = cmd.scan_en && rd_vld_r &&
                   ((rd_idx_r == '0) || (rd_data_r.prio > best_r.prio));

  always_comb begin
    priority if (in_action == pqls_pkg::ACT_ENQ && full) begin
      st_in = pqls_pkg::ST_FULL;
    end else if ((in_action == pqls_pkg::ACT_PEEK || in_action == pqls_pkg::ACT_DEQ) &&
                 empty) begin
      st_in = pqls_pkg::ST_EMPTY;
    end else begin
      st_in = pqls_pkg::ST_OK;
    end
  end

  // single write port: append on enqueue, move down one on shift
  always_comb begin
    if (cmd.enq_wr) begin
      wr_en   = 1'b1;
      wr_addr = fill_r[IW-1:0];
      wr_data = item_r;
    end else begin
      wr_en   = cmd.shift_en && rd_vld_r;
      wr_addr = rd_idx_r - IW'(1);
      wr_data = rd_data_r;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_go) begin
      rd_data_r <= mem[ptr_r[IW-1:0]];
      rd_idx_r  <= ptr_r[IW-1:0];
    end
  end

  always_comb begin
    fill_nxt = fill_r;
    if (cmd.enq_wr) begin
      fill_nxt = fill_r + CW'(1);
    end else if (cmd.fill_dec) begin
      fill_nxt = fill_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r   <= '0;
      ptr_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      fill_r <= fill_nxt;
      if (cmd.item_load) begin
        ptr_r    <= '0;
        rd_vld_r <= 1'b0;
      end else if (cmd.shift_start) begin
        ptr_r    <= CW'(best_idx_r) + CW'(1);
        rd_vld_r <= 1'b0;
      end else if (walking) begin
        rd_vld_r <= rd_go;
        if (rd_go) begin
          ptr_r <= ptr_r + CW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.item_load) begin
      act_r        <= in_action;
      item_r.value <= in_item_value;
      item_r.prio  <= in_item_priority;
      st_r         <= st_in;
    end
    if (take) begin
      best_idx_r <= rd_idx_r;
      best_r     <= rd_data_r;
    end
  end

  // result register
  assign returns_entry = (st_r == pqls_pkg::ST_OK) &&
                         (act_r == pqls_pkg::ACT_PEEK || act_r == pqls_pkg::ACT_DEQ);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_vld_r <= 1'b1;
    end else if (out_ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_value_r <= returns_entry ? best_r.value : '0;
      out_prio_r  <= returns_entry ? best_r.prio : '0;
      out_st_r    <= st_r;
      out_cnt_r   <= fill_r;
    end
  end

  assign sts.full      = full;
  assign sts.empty     = empty;
  assign sts.walk_done = (ptr_r >= fill_r) && !rd_vld_r;
  assign sts.is_deq    = (act_r == pqls_pkg::ACT_DEQ);
  assign sts.out_vld   = out_vld_r;

  assign out_valid       = out_vld_r;
  assign out_value       = out_value_r;
  assign out_priority    = out_prio_r;
  assign out_status      = out_st_r;
  assign out_entry_count = out_cnt_r;

  a_no_enq_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.enq_wr |-> !full)
    else $error("enqueue write with queue full");

  a_fill_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.fill_dec |-> !empty ##1 (fill_r == $past(fill_r) - CW'(1)))
    else $error("fill count decrement out of range");

  a_shift_above_best: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.shift_en && rd_vld_r) |-> (rd_idx_r > best_idx_r))
    else $error("shift write at or below removed entry");

  a_no_result_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_vld_r || out_ready))
    else $error("result register overwritten before transaction");

endmodule

`default_nettype wire

// ----- rtl/core/priority_queue_linear_scan_top.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Channel  Dir  Handshake             Payload
// in       in   in_valid / in_ready   in_action, in_item_value, in_item_priority
// out      out  out_valid / out_ready out_value, out_priority, out_status, out_entry_count
//
// One transaction in gives exactly one transaction out, in order.
// Steps from the accepting edge: enqueue writes the entry, then loads the result; full,
// empty or unused action loads the result directly; peek scans all entries; dequeue
// scans, then shifts the entries above the removed slot k down one place.
// The entry memory gives one registered read and one write per cycle: the max scan
// visits one entry a cycle, the shift moves one entry a cycle. in_ready returns the
// cycle after the result load.
// Reset (rst_n low, synchronous) empties the queue; entry contents are not cleared.
// A result waiting in the output register does not stop a new input transaction;
// only the next result load waits for out_ready.

module priority_queue_linear_scan_top (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic [1:0]                        in_action,
  input  wire logic signed [pqls_pkg::VAL_W-1:0] in_item_value,
  input  wire logic signed [pqls_pkg::PRI_W-1:0] in_item_priority,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic signed [pqls_pkg::VAL_W-1:0]      out_value,
  output logic signed [pqls_pkg::PRI_W-1:0]      out_priority,
  output logic [1:0]                             out_status,
  output logic [pqls_pkg::CNT_W-1:0]             out_entry_count
);

  pqls_pkg::cmd_t cmd;
  pqls_pkg::sts_t sts;

  // sequencer: decode on accept, enqueue write or scan, optional shift, result load
  pqls_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_action (in_action),
    .in_ready  (in_ready),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // entry memory, fill count, max tracker and result register
  pqls_dpath u_dpath (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_action        (in_action),
    .in_item_value    (in_item_value),
    .in_item_priority (in_item_priority),
    .out_ready        (out_ready),
    .cmd              (cmd),
    .sts              (sts),
    .out_valid        (out_valid),
    .out_value        (out_value),
    .out_priority     (out_priority),
    .out_status       (out_status),
    .out_entry_count  (out_entry_count)
  );

endmodule

`default_nettype wire
